// File: design/per_source_trend_threshold_top_macros.svh
// Assertion macros for the per-source trend threshold block.
// Used by the port checker; clocked on aclk, disabled while aresetn is low.
`ifndef PER_SOURCE_TREND_THRESHOLD_TOP_MACROS_SVH
`define PER_SOURCE_TREND_THRESHOLD_TOP_MACROS_SVH

// same-cycle implication
`define PSTT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pstt check failed");

// next-cycle implication
`define PSTT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pstt check failed");

`endif

// File: design/pstt_pkg.sv
// Shared constants for the per-source trend threshold block.
// No dependencies; imported by the top level and its port checker.
package pstt_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int WINDOW_LENGTH = 16;

    localparam int ENT_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PTR_W  = $clog2(WINDOW_LENGTH);
    localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
    localparam int ADDR_W = $clog2(TABLE_ENTRIES * WINDOW_LENGTH);

    localparam int SRC_W   = 16;
    localparam int VAL_W   = 16;
    localparam int TIME_W  = 32;
    localparam int TO_W    = 16;
    localparam int MINS_W  = 5;
    localparam int SLOPE_W = 17;
    localparam int DEC_W   = 2;

    // sum and product widths
    localparam int SY_W   = VAL_W + CNT_W;
    localparam int SX_W   = 2 * CNT_W;
    localparam int SXY_W  = VAL_W + 2 * CNT_W;
    localparam int SXX_W  = 3 * CNT_W;
    localparam int PRD_W  = VAL_W + 3 * CNT_W;
    localparam int NUM_W  = PRD_W + 1;
    localparam int DEN_W  = 4 * CNT_W;
    localparam int DCNT_W = $clog2(NUM_W + 1);

    localparam int SLOPE_MAX = 65535;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 24;

    localparam logic [DEC_W-1:0] DEC_CLOSE = 2'd0;
    localparam logic [DEC_W-1:0] DEC_OPEN  = 2'd1;
    localparam logic [DEC_W-1:0] DEC_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

endpackage

// File: design/per_source_trend_threshold_top.sv
// Per-source trend detector: source table, sample windows, serial slope divider.
// Depends on pstt_pkg.
//
//  channel | dir | beat contents (low bits first)
//  s_      | in  | source_address[15:0], sample_value[31:16], current_time[63:32]
//  m_      | out | decision[1:0], trend_slope[18:2], zero pad
//  cfg_    | in  | cfg_index selects register, cfg_data carries value
//
// One item at a time: accept, a scan of up to TABLE_ENTRIES entries, the update,
// a memory read and an accumulate per window sample, the products and differences,
// the NUM_W quotient bits of the divider, then the final slope and the hand-over.
// The restoring divider produces one quotient bit a cycle.
// aresetn is synchronous; it frees all entries and restores register defaults.
// A held result stalls only the final hand-over; s_tready is high when idle.
module per_source_trend_threshold_top import pstt_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // source_address, sample_value, current_time
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // decision, trend_slope, pad
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SCAN = 4'd1;
    localparam logic [3:0] ST_UPD  = 4'd2;
    localparam logic [3:0] ST_RD   = 4'd3;
    localparam logic [3:0] ST_ACC  = 4'd4;
    localparam logic [3:0] ST_PROD = 4'd5;
    localparam logic [3:0] ST_DIFF = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic [3:0]               state_reg;
    logic [TO_W-1:0]          timeout_reg;
    logic [MINS_W-1:0]        min_samp_reg;
    logic signed [SLOPE_W-1:0] thr_reg;

    logic [SRC_W-1:0]         src_reg;
    logic [VAL_W-1:0]         val_reg;
    logic [TIME_W-1:0]        now_reg;

    logic [TABLE_ENTRIES-1:0] used_reg;
    logic [SRC_W-1:0]         ent_addr_reg [TABLE_ENTRIES];
    logic [TIME_W-1:0]        ent_seen_reg [TABLE_ENTRIES];
    logic [PTR_W-1:0]         ent_head_reg [TABLE_ENTRIES];
    logic [PTR_W-1:0]         ent_tail_reg [TABLE_ENTRIES];

    logic [VAL_W-1:0]         sample_mem [TABLE_ENTRIES * WINDOW_LENGTH];
    logic [VAL_W-1:0]         rd_data_reg;

    logic [ENT_W-1:0]         idx_reg;
    logic [ENT_W-1:0]         pick_reg;
    logic                     pick_vld_reg;
    logic [ENT_W-1:0]         ent_reg;

    logic [PTR_W-1:0]         head_reg;
    logic [CNT_W-1:0]         n_reg;
    logic [CNT_W-1:0]         k_reg;
    logic [SY_W-1:0]          sy_reg;
    logic [SX_W-1:0]          sx_reg;
    logic [SXY_W-1:0]         sxy_reg;
    logic [SXX_W-1:0]         sxx_reg;
    logic [PRD_W-1:0]         pa_reg, pb_reg;
    logic [DEN_W-1:0]         pc_reg, pd_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [NUM_W-1:0]         quo_reg;
    logic                     neg_reg;
    logic [DCNT_W-1:0]        dcnt_reg;

    logic [DEC_W-1:0]         dec_reg;
    logic signed [SLOPE_W-1:0] slope_reg;
    logic                     m_valid_reg;
    logic [OUT_TDATA_W-1:0]   m_data_reg;

    // scan of one table entry
    logic                     cur_used, cur_match, cur_expired, take_free, hit, last_idx;
    logic                     pick_vld_next;
    logic [ENT_W-1:0]         pick_next;

    always_comb begin
        cur_used    = used_reg[idx_reg];
        cur_match   = (ent_addr_reg[idx_reg] == src_reg);
        cur_expired = {1'b0, now_reg} >
                      ({1'b0, ent_seen_reg[idx_reg]} + (TIME_W + 1)'(timeout_reg));
        take_free   = !cur_used && !pick_vld_reg;
        hit         = !take_free && cur_match;
        last_idx    = (idx_reg == ENT_W'(TABLE_ENTRIES - 1));
        pick_vld_next = pick_vld_reg;
        pick_next     = pick_reg;
        if (!pick_vld_reg && (take_free || (cur_used && cur_expired))) begin
            pick_vld_next = 1'b1;
            pick_next     = idx_reg;
        end
    end

    // window update for the chosen entry
    logic                     e_used, e_full, judge;
    logic [PTR_W-1:0]         h_cur, t_cur, h_new, t_new;
    logic [CNT_W:0]           cnt_raw;
    logic [CNT_W-1:0]         cnt, n_new;

    always_comb begin
        e_used  = used_reg[ent_reg];
        h_cur   = e_used ? ent_head_reg[ent_reg] : '0;
        t_cur   = e_used ? ent_tail_reg[ent_reg] : '0;
        e_full  = e_used && (h_cur == t_cur);
        h_new   = e_full ? ptr_inc(h_cur) : h_cur;
        t_new   = ptr_inc(t_cur);
        cnt_raw = (CNT_W + 1)'(t_new) + (CNT_W + 1)'(WINDOW_LENGTH) - (CNT_W + 1)'(h_new);
        cnt     = (cnt_raw >= (CNT_W + 1)'(WINDOW_LENGTH)) ?
                  CNT_W'(cnt_raw - (CNT_W + 1)'(WINDOW_LENGTH)) : CNT_W'(cnt_raw);
        judge   = e_full || ((MINS_W + 1)'(cnt) > (MINS_W + 1)'(min_samp_reg));
        n_new   = (cnt == '0) ? CNT_W'(WINDOW_LENGTH) : cnt;
    end

    // memory addresses
    logic [PTR_W:0]           pos_raw;
    logic [PTR_W-1:0]         pos;
    logic [ADDR_W-1:0]        rd_addr, wr_addr;

    always_comb begin
        pos_raw = (PTR_W + 1)'(head_reg) + (PTR_W + 1)'(k_reg[PTR_W-1:0]);
        pos     = (pos_raw >= (PTR_W + 1)'(WINDOW_LENGTH)) ?
                  PTR_W'(pos_raw - (PTR_W + 1)'(WINDOW_LENGTH)) : PTR_W'(pos_raw);
        rd_addr = ADDR_W'(ent_reg) * ADDR_W'(WINDOW_LENGTH) + ADDR_W'(pos);
        wr_addr = ADDR_W'(ent_reg) * ADDR_W'(WINDOW_LENGTH) + ADDR_W'(t_cur);
    end

    // divider step and final slope
    logic signed [NUM_W-1:0]  num;
    logic [DEN_W:0]           rem_sh;
    logic                     q_bit;
    logic [SLOPE_W-1:0]       mag;
    logic signed [SLOPE_W-1:0] slope_fin;

    always_comb begin
        num    = $signed({1'b0, pa_reg}) - $signed({1'b0, pb_reg});
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        q_bit  = (rem_sh >= {1'b0, den_reg});
        mag    = (quo_reg > NUM_W'(SLOPE_MAX)) ? SLOPE_W'(SLOPE_MAX) : quo_reg[SLOPE_W-1:0];
        slope_fin = neg_reg ? -$signed(mag) : $signed(mag);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // sample store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (state_reg == ST_UPD) begin
            sample_mem[wr_addr] <= val_reg;
        end
        rd_data_reg <= sample_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg  <= TO_W'(60);
            min_samp_reg <= MINS_W'(4);
            thr_reg      <= SLOPE_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TIMEOUT:   timeout_reg  <= cfg_data[TO_W-1:0];
                CFG_MIN_SAMP:  min_samp_reg <= cfg_data[MINS_W-1:0];
                CFG_THRESHOLD: thr_reg      <= $signed(cfg_data[SLOPE_W-1:0]);
                default: ;
            endcase
        end
    end

    // sequencer and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // drop an accepted beat unless the hand-over below replaces it
            if (m_valid_reg && m_tready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        src_reg      <= s_tdata[SRC_W-1:0];
                        val_reg      <= s_tdata[SRC_W+VAL_W-1:SRC_W];
                        now_reg      <= s_tdata[SRC_W+VAL_W+TIME_W-1:SRC_W+VAL_W];
                        idx_reg      <= '0;
                        pick_vld_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // free timed-out entries scanned before a hit
                    if (!hit && cur_used && cur_expired) begin
                        used_reg[idx_reg] <= 1'b0;
                    end
                    pick_reg     <= pick_next;
                    pick_vld_reg <= pick_vld_next;
                    if (hit) begin
                        ent_reg   <= idx_reg;
                        state_reg <= ST_UPD;
                    end else if (last_idx) begin
                        if (pick_vld_next) begin
                            ent_reg   <= pick_next;
                            state_reg <= ST_UPD;
                        end else begin
                            dec_reg   <= DEC_FULL;
                            slope_reg <= '0;
                            state_reg <= ST_OUT;
                        end
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_UPD: begin
                    used_reg[ent_reg]     <= 1'b1;
                    ent_addr_reg[ent_reg] <= src_reg;
                    ent_seen_reg[ent_reg] <= now_reg;
                    ent_head_reg[ent_reg] <= h_new;
                    ent_tail_reg[ent_reg] <= t_new;
                    head_reg <= h_new;
                    n_reg    <= n_new;
                    k_reg    <= '0;
                    sy_reg   <= '0;
                    sx_reg   <= '0;
                    sxy_reg  <= '0;
                    sxx_reg  <= '0;
                    quo_reg  <= '0;
                    neg_reg  <= 1'b0;
                    if (!judge) begin
                        dec_reg   <= DEC_CLOSE;
                        slope_reg <= '0;
                        state_reg <= ST_OUT;
                    end else if (n_new < CNT_W'(2)) begin
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_RD;
                    end
                end
                ST_RD: begin
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    // accumulate one sample at position k
                    sy_reg  <= sy_reg + SY_W'(rd_data_reg);
                    sx_reg  <= sx_reg + SX_W'(k_reg);
                    sxx_reg <= sxx_reg + SXX_W'(SXX_W'(k_reg) * SXX_W'(k_reg));
                    sxy_reg <= sxy_reg + SXY_W'((SXY_W)'(k_reg) * (SXY_W)'(rd_data_reg));
                    if (k_reg == n_reg - 1'b1) begin
                        state_reg <= ST_PROD;
                    end else begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_RD;
                    end
                end
                ST_PROD: begin
                    pa_reg    <= PRD_W'(PRD_W'(n_reg) * PRD_W'(sxy_reg));
                    pb_reg    <= PRD_W'(PRD_W'(sx_reg) * PRD_W'(sy_reg));
                    pc_reg    <= DEN_W'(DEN_W'(n_reg) * DEN_W'(sxx_reg));
                    pd_reg    <= DEN_W'(DEN_W'(sx_reg) * DEN_W'(sx_reg));
                    state_reg <= ST_DIFF;
                end
                ST_DIFF: begin
                    den_reg   <= pc_reg - pd_reg;
                    neg_reg   <= num[NUM_W-1];
                    quo_reg   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
                    rem_reg   <= '0;
                    dcnt_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // one restoring step: shift in a dividend bit, trial subtract
                    rem_reg  <= q_bit ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
                    quo_reg  <= {quo_reg[NUM_W-2:0], q_bit};
                    dcnt_reg <= dcnt_reg + 1'b1;
                    if (dcnt_reg == DCNT_W'(NUM_W - 1)) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    slope_reg <= slope_fin;
                    dec_reg   <= (slope_fin >= thr_reg) ? DEC_OPEN : DEC_CLOSE;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // hand over once the output register is free
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= OUT_TDATA_W'({slope_reg, dec_reg});
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: design/pstt_checker.sv
// Port checker for the per-source trend threshold block, bound to the top level.
// Depends on pstt_pkg and per_source_trend_threshold_top_macros.svh.
`include "per_source_trend_threshold_top_macros.svh"

module pstt_checker import pstt_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   cfg_wr_en,
    input logic [CFG_IDX_W-1:0]   cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    // a stalled result beat holds
    `PSTT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // an accepted item keeps the block busy for the next cycle
    `PSTT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // no undefined decision code
    `PSTT_ASSERT_NOW(a_dec_code, m_tvalid, m_tdata[1:0] != 2'd3)

    // a dropped sample reports no slope
    `PSTT_ASSERT_NOW(a_full_zero, m_tvalid && (m_tdata[1:0] == DEC_FULL),
                     m_tdata[18:2] == 17'd0)

endmodule

bind per_source_trend_threshold_top pstt_checker u_pstt_checker (.*);

// File: tb/tb_per_source_trend_threshold_top.sv
// Self-checking testbench for per_source_trend_threshold_top: a scoreboard class predicts
// each beat's decision and slope from its own source table; tasks drive the stream and cfg ports.
// Depends on pstt_pkg and the block's RTL only.
module tb_per_source_trend_threshold_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pstt_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind this index
    localparam int RUN_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 120;
    localparam int POOL = 12;

    // Model of the source table, its windows and the slope judgement
    class trend_scoreboard;
        bit                     used [TABLE_ENTRIES];
        bit                     written [TABLE_ENTRIES];
        logic [SRC_W-1:0]       addr [TABLE_ENTRIES];
        logic [TIME_W-1:0]      seen [TABLE_ENTRIES];
        logic [PTR_W-1:0]       head [TABLE_ENTRIES];
        logic [PTR_W-1:0]       tail [TABLE_ENTRIES];
        logic [VAL_W-1:0]       samples [TABLE_ENTRIES][WINDOW_LENGTH];
        logic [TO_W-1:0]        timeout;
        logic [MINS_W-1:0]      min_count;
        logic signed [SLOPE_W-1:0] threshold;
        logic [DEC_W-1:0]       exp_decision [$];
        logic signed [SLOPE_W-1:0] exp_slope [$];
        int n_full, n_open, n_close, n_judged;

        function new();
            timeout = 16'd60;
            min_count = 5'd4;
            threshold = 17'sd1;
            foreach (used[i]) begin
                used[i] = 0;
                written[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TIMEOUT:   timeout = val[TO_W-1:0];
                CFG_MIN_SAMP:  min_count = val[MINS_W-1:0];
                CFG_THRESHOLD: threshold = val;
                default: ;
            endcase
        endfunction

        function bit table_primed();
            foreach (written[i])
                if (!written[i]) return 0;
            return 1;
        endfunction

        function int lookup(logic [SRC_W-1:0] a, logic [TIME_W-1:0] now);
            int pick;
            pick = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (!used[i] && pick < 0) begin
                    pick = i;
                end else if (addr[i] == a) begin
                    return i;
                end
                if (used[i] && longint'(now) > longint'(seen[i]) + longint'(timeout)) begin
                    used[i] = 0;
                    if (pick < 0) pick = i;
                end
            end
            return pick;
        endfunction

        function longint fit_slope(int e, int n);
            longint sx, sy, sxy, sxx, y, num, den, q;
            logic [PTR_W-1:0] pos;
            sx = 0; sy = 0; sxy = 0; sxx = 0;
            if (n < 2) return 0;
            for (int k = 0; k < n; k++) begin
                pos = head[e] + PTR_W'(k);
                y = longint'(samples[e][pos]);
                sx += k;
                sy += y;
                sxy += k * y;
                sxx += k * k;
            end
            num = n * sxy - sx * sy;
            den = n * sxx - sx * sx;
            if (den <= 0) return 0;
            q = num / den;
            if (q > SLOPE_MAX) q = SLOPE_MAX;
            if (q < -SLOPE_MAX) q = -SLOPE_MAX;
            return q;
        endfunction

        // Note an accepted sample and queue the result it must produce
        function void note_sample(logic [SRC_W-1:0] a, logic [VAL_W-1:0] v,
                                  logic [TIME_W-1:0] now);
            int e, n;
            bit judge;
            logic [PTR_W-1:0] count;
            longint slope;
            logic [DEC_W-1:0] dec;
            e = lookup(a, now);
            if (e < 0) begin
                exp_decision.push_back(DEC_FULL);
                exp_slope.push_back('0);
                n_full++;
                return;
            end
            judge = 0;
            if (used[e]) begin
                if (head[e] == tail[e]) begin
                    judge = 1;
                    head[e] = head[e] + 1'b1;
                end
            end else begin
                used[e] = 1;
                written[e] = 1;
                addr[e] = a;
                head[e] = '0;
                tail[e] = '0;
            end
            seen[e] = now;
            samples[e][tail[e]] = v;
            tail[e] = tail[e] + 1'b1;
            count = tail[e] - head[e];
            if (5'(count) > min_count) judge = 1;
            slope = 0;
            dec = DEC_CLOSE;
            if (judge) begin
                n = (count == 0) ? WINDOW_LENGTH : int'(count);
                slope = fit_slope(e, n);
                dec = (slope >= longint'(threshold)) ? DEC_OPEN : DEC_CLOSE;
                n_judged++;
            end
            if (dec == DEC_OPEN) n_open++; else n_close++;
            exp_decision.push_back(dec);
            exp_slope.push_back(SLOPE_W'(slope));
        endfunction

        // Compare one result beat with the oldest expectation; nonzero on mismatch
        function int check_result(logic [OUT_TDATA_W-1:0] beat, output string msg);
            logic [DEC_W-1:0] d;
            logic signed [SLOPE_W-1:0] s;
            if (exp_decision.size() == 0) begin
                msg = $sformatf("unexpected result beat %h", beat);
                return 1;
            end
            d = exp_decision.pop_front();
            s = exp_slope.pop_front();
            msg = "";
            if (beat[1:0] != d)
                msg = {msg, $sformatf(" decision got %0d want %0d", beat[1:0], d)};
            if (beat[2 +: SLOPE_W] != s)
                msg = {msg, $sformatf(" slope got %0d want %0d",
                                      $signed(beat[2 +: SLOPE_W]), s)};
            return (msg != "");
        endfunction
    endclass

    logic aclk, aresetn;
    logic s_tvalid, s_tready, m_tvalid, m_tready, cfg_wr_en;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    trend_scoreboard sb;
    int mismatches = 0;
    int results_seen = 0;
    int cycles = 0;
    bit long_hold_req = 0;
    bit quiet_sender = 0;
    bit quiet_receiver = 0;
    logic [SRC_W-1:0]  pool_addr [POOL];
    logic [VAL_W-1:0]  ramp_level [POOL];
    int                ramp_step [POOL];
    logic [TIME_W-1:0] clock_s;

    per_source_trend_threshold_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_per_source_trend_threshold_top: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch:%s", $realtime, msg);
    endtask

    // Result side: check each accepted beat, then draw the next stall
    initial begin : result_side
        int hold;
        string msg;
        hold = 0;
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                results_seen++;
                if (sb.check_result(m_tdata, msg)) report_mismatch(msg);
                hold = quiet_receiver ? 0 : int'($urandom_range(0, 17));
            end
            if (long_hold_req) begin
                long_hold_req = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic write_regs(logic [TO_W-1:0] to, logic [MINS_W-1:0] mins,
                              logic signed [SLOPE_W-1:0] thr);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_TIMEOUT;   cfg_data <= CFG_DATA_W'(to);
        @(posedge aclk);
        sb.write_reg(CFG_TIMEOUT, CFG_DATA_W'(to));
        cfg_index <= CFG_MIN_SAMP;  cfg_data <= CFG_DATA_W'(mins);
        @(posedge aclk);
        sb.write_reg(CFG_MIN_SAMP, CFG_DATA_W'(mins));
        cfg_index <= CFG_THRESHOLD; cfg_data <= thr;
        @(posedge aclk);
        sb.write_reg(CFG_THRESHOLD, thr);
        cfg_wr_en <= 1'b0;
    endtask

    // Withdraw any offered beat and wait until every expected result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.exp_decision.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // Offer one beat, hold it until taken, then idle for a drawn gap
    task automatic send_sample(logic [SRC_W-1:0] a, logic [VAL_W-1:0] v,
                               logic [TIME_W-1:0] now);
        int gap;
        if (!sb.table_primed() && a == '0) a = 16'd1;
        s_tvalid <= 1'b1;
        s_tdata <= {now, v, a};
        do @(posedge aclk); while (!s_tready);
        sb.note_sample(a, v, now);
        gap = quiet_sender ? 0 : int'($urandom_range(0, 17));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Random phase: ramps with noise on a small source pool, some noise items
    task automatic run_phase(int items, int hold_at, int pause_at);
        int p, noise;
        logic [VAL_W-1:0] v;
        logic [TIME_W-1:0] now;
        for (int i = 0; i < POOL; i++) begin
            pool_addr[i] = SRC_W'($urandom_range(0, 65535));
            ramp_level[i] = VAL_W'($urandom_range(0, 65535));
            ramp_step[i] = int'($urandom_range(0, 4000)) - 2000;
        end
        quiet_sender = 0;
        quiet_receiver = 0;
        for (int k = 0; k < items; k++) begin
            if (k % 50 == 20) quiet_sender = ~quiet_sender;
            if (k % 70 == 35) quiet_receiver = ~quiet_receiver;
            if (k == hold_at) long_hold_req = 1;
            if (k == pause_at) wait_drained();
            p = int'($urandom_range(0, POOL - 1));
            case ($urandom_range(0, 19))
                0: clock_s = clock_s + sb.timeout + $urandom_range(1, 3);
                1: clock_s = $urandom;
                2: clock_s = clock_s - $urandom_range(0, 100);
                default: clock_s = clock_s + $urandom_range(0, 3);
            endcase
            now = clock_s;
            noise = int'($urandom_range(0, 200)) - 100;
            case ($urandom_range(0, 9))
                0: v = VAL_W'($urandom);
                1: v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
                default: v = VAL_W'(int'(ramp_level[p]) + ramp_step[p] + noise);
            endcase
            ramp_level[p] = VAL_W'(int'(ramp_level[p]) + ramp_step[p]);
            if ($urandom_range(0, 15) == 0)
                send_sample(SRC_W'($urandom), v, now);
            else
                send_sample(pool_addr[p], v, now);
        end
        s_tvalid <= 1'b0;
        wait_drained();
    endtask

    initial begin
        sb = new();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        cfg_wr_en = 0;
        cfg_index = CFG_TIMEOUT;
        cfg_data = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fill the table, overflow it, ramp one source, swing another, then expire all
        clock_s = 32'd1000;
        for (int i = 1; i <= TABLE_ENTRIES; i++)
            send_sample(SRC_W'(i), VAL_W'(i * 10), clock_s);
        send_sample(16'd9, 16'd5, clock_s);
        for (int i = 0; i < 6; i++)
            send_sample(16'd1, VAL_W'(100 * i), clock_s + i);
        send_sample(16'd2, 16'hFFFF, clock_s + 2);
        send_sample(16'd2, 16'h0000, clock_s + 3);
        send_sample(16'd2, 16'hFFFF, clock_s + 4);
        send_sample(16'd2, 16'h0000, clock_s + 5);
        send_sample(16'd2, 16'h0000, clock_s + 6);
        send_sample(16'h0000, 16'h1234, 32'hFFFF_FFFF);
        send_sample(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_sample(16'h0000, 16'h1300, 32'hFFFF_FFFF);
        s_tvalid <= 1'b0;
        wait_drained();

        // Spare index must leave the registers alone
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SPARE;
        cfg_data <= '1;
        @(posedge aclk);
        sb.write_reg(CFG_SPARE, '1);
        cfg_wr_en <= 1'b0;
        clock_s = 32'd0;
        run_phase(80, 30, 60);

        write_regs(16'd0, 5'd0, -17'sd65535);
        run_phase(90, -1, 45);
        write_regs(16'hFFFF, 5'd16, 17'sd65535);
        run_phase(110, 50, -1);
        write_regs(16'd5, 5'd1, 17'sd0);
        run_phase(90, -1, 40);
        write_regs(16'd1000, 5'd15, -17'sd3);
        run_phase(100, 20, 70);
        write_regs(TO_W'($urandom), MINS_W'($urandom_range(0, 16)),
                   SLOPE_W'($urandom_range(0, 131071)));
        run_phase(100, -1, 50);

        repeat (SETTLE_CYCLES) @(posedge aclk);
        while (sb.exp_decision.size() != 0) @(posedge aclk);
        $display("covered %0d results: %0d open, %0d close, %0d table full, %0d slopes judged",
                 results_seen, sb.n_open, sb.n_close, sb.n_full, sb.n_judged);
        $display("register settings swept across six phases, %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("tb_per_source_trend_threshold_top: PASS");
        end else begin
            $display("tb_per_source_trend_threshold_top: FAIL");
        end
        $finish;
    end
endmodule
